/* design/ray_two_box_hit_order_defines.svh */
`ifndef RAY_TWO_BOX_HIT_ORDER_DEFINES_SVH
`define RAY_TWO_BOX_HIT_ORDER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define RTBHO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define RTBHO_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* design/rtbho_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rtbho_pkg;

	// Three spatial axes
	localparam int AXES = 3;

	// Register map, index within the configuration space
	typedef enum logic [2:0] {
		REG_ORIGIN_X  = 3'd0,
		REG_ORIGIN_Y  = 3'd1,
		REG_ORIGIN_Z  = 3'd2,
		REG_HEADING_X = 3'd3,
		REG_HEADING_Y = 3'd4,
		REG_HEADING_Z = 3'd5
	} reg_idx_t;

	// Result codes
	typedef enum logic [2:0] {
		HIT_NONE          = 3'd0,
		HIT_FIRST         = 3'd1,
		HIT_SECOND        = 3'd2,
		HIT_FIRST_NEARER  = 3'd3,
		HIT_SECOND_NEARER = 3'd4
	} hit_order_t;

	// Divider output status
	typedef struct packed {
		logic valid;
		logic ok;
	} div_flag_t;

	// Face test output status
	typedef struct packed {
		logic valid;
		logic hit;
	} face_flag_t;

endpackage

`default_nettype wire

/* design/rtbho_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "ray_two_box_hit_order_defines.svh"

module rtbho_cfg #(
	parameter int CW       = 32,
	parameter int DW       = 32,
	parameter int ADDR_LSB = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ADDR_LSB+2:0]                  paddr,
	input  logic [DW-1:0]                        pwdata,
	output logic [DW-1:0]                        prdata,
	output logic                                 pready,
	output logic [rtbho_pkg::AXES-1:0][CW-1:0]   org,
	output logic [rtbho_pkg::AXES-1:0][CW-1:0]   hdg
);
	import rtbho_pkg::*;

	logic signed [CW-1:0] org_q [AXES];
	logic signed [CW-1:0] hdg_q [AXES];
	logic                 wr_en;
	logic [2:0]           ridx;
	logic signed [DW-1:0] rd_val;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign ridx   = paddr[ADDR_LSB+2:ADDR_LSB];

	// Write one register per access beat; unknown indices drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				org_q[i] <= '0;
				hdg_q[i] <= '0;
			end
		end else if (wr_en) begin
			case (reg_idx_t'(ridx))
				REG_ORIGIN_X:  org_q[0] <= pwdata[CW-1:0];
				REG_ORIGIN_Y:  org_q[1] <= pwdata[CW-1:0];
				REG_ORIGIN_Z:  org_q[2] <= pwdata[CW-1:0];
				REG_HEADING_X: hdg_q[0] <= pwdata[CW-1:0];
				REG_HEADING_Y: hdg_q[1] <= pwdata[CW-1:0];
				REG_HEADING_Z: hdg_q[2] <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	// Read back, sign-extended to the bus width
	always_comb begin
		case (reg_idx_t'(ridx))
			REG_ORIGIN_X:  rd_val = org_q[0];
			REG_ORIGIN_Y:  rd_val = org_q[1];
			REG_ORIGIN_Z:  rd_val = org_q[2];
			REG_HEADING_X: rd_val = hdg_q[0];
			REG_HEADING_Y: rd_val = hdg_q[1];
			REG_HEADING_Z: rd_val = hdg_q[2];
			default:       rd_val = '0;
		endcase
	end
	assign prdata = rd_val;

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			org[i] = org_q[i];
			hdg[i] = hdg_q[i];
		end
	end

	`RTBHO_ASSERT_NXT(a_cfg_hdg_x_wr, clk, arst_n, wr_en && (ridx == REG_HEADING_X), hdg_q[0] == $past(pwdata[CW-1:0]), "heading X write lost")

endmodule

`default_nettype wire

/* design/rtbho_div.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "ray_two_box_hit_order_defines.svh"

// Pipelined restoring divider: one saturation stage, then one quotient bit
// per stage.
module rtbho_div #(
	parameter int CW   = 32,
	parameter int FRAC = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [CW+FRAC:0]           nmag,
	input  logic [CW-1:0]              dmag,
	input  logic                       neg,
	input  logic                       zero,
	output rtbho_pkg::div_flag_t       flag,
	output logic [CW-2:0]              quot
);
	import rtbho_pkg::*;

	localparam int NM = CW + 1 + FRAC;
	localparam int QB = CW - 1;
	localparam int D  = CW;
	localparam int RW = (NM > CW + QB) ? NM : CW + QB;

	logic [RW-1:0] rem_s  [D];
	logic [QB-1:0] q_s    [D];
	logic          sat_s  [D];
	logic          neg_s  [D];
	logic          zero_s [D];
	logic          vld_s  [D];

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) vld_s[i] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < D; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// Saturation stage: quotient would need more than QB bits
	always_ff @(posedge clk) begin
		rem_s[0]  <= RW'(nmag);
		q_s[0]    <= '0;
		sat_s[0]  <= RW'(nmag) >= (RW'(dmag) << QB);
		neg_s[0]  <= neg;
		zero_s[0] <= zero;
	end

	// One quotient bit per stage, most significant first
	for (genvar j = 1; j < D; j++) begin : g_stage
		localparam int BIT = QB - j;
		logic [RW-1:0] dsh;
		assign dsh = RW'(dmag) << BIT;

		always_ff @(posedge clk) begin
			if (rem_s[j-1] >= dsh) begin
				rem_s[j] <= rem_s[j-1] - dsh;
				q_s[j]   <= q_s[j-1] | (QB'(1) << BIT);
			end else begin
				rem_s[j] <= rem_s[j-1];
				q_s[j]   <= q_s[j-1];
			end
			sat_s[j]  <= sat_s[j-1];
			neg_s[j]  <= neg_s[j-1];
			zero_s[j] <= zero_s[j-1];
		end
	end

	// Negative nonzero quotient or zero divisor is a miss; clamp on overflow
	assign flag.valid = vld_s[D-1];
	assign flag.ok    = !zero_s[D-1] && !(neg_s[D-1] && (sat_s[D-1] || (q_s[D-1] != '0)));
	assign quot       = sat_s[D-1] ? '1 : q_s[D-1];

	`RTBHO_ASSERT_IMP(a_div_lat, clk, arst_n, flag.valid, $past(in_valid, D), "divider beat without entry")

endmodule

`default_nettype wire

/* design/rtbho_face.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "ray_two_box_hit_order_defines.svh"

// One face test: distance by division, then the two cross coordinates
// checked against the face bounds.
module rtbho_face #(
	parameter int CW   = 32,
	parameter int FRAC = 16,
	parameter int AXIS = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic signed [CW-1:0]                 plane,
	input  logic [3:0][CW-1:0]                   bnd,
	input  logic [rtbho_pkg::AXES-1:0][CW-1:0]   org,
	input  logic [rtbho_pkg::AXES-1:0][CW-1:0]   hdg,
	output rtbho_pkg::face_flag_t                flag,
	output logic [CW-2:0]                        face_dist
);
	import rtbho_pkg::*;

	localparam int U  = (AXIS + 1) % AXES;
	localparam int V  = (AXIS + 2) % AXES;
	localparam int NM = CW + 1 + FRAC;
	localparam int D  = CW;
	localparam int XW = 2 * CW + 1;

	logic signed [CW-1:0] org_a, dir_a, org_u, org_v, hdg_u, hdg_v;
	logic signed [CW:0]   diff;
	logic [CW:0]          adiff;
	logic [CW-1:0]        dmag;

	logic                 vld_s1, neg_s1, zero_s1;
	logic [NM-1:0]        nmag_s1;
	logic [3:0][CW-1:0]   bnd_s1;

	div_flag_t            div_flag;
	logic [CW-2:0]        div_t;
	logic [3:0][CW-1:0]   bnd_dly_q [D];
	logic signed [CW-1:0] t_ext;

	logic                     vld_s2, ok_s2, vld_s3, ok_s3, vld_s4, hit_s4;
	logic signed [2*CW-1:0]   prod_u_s2, prod_v_s2, sh_u, sh_v;
	logic [CW-2:0]            t_s2, t_s3, dist_s4;
	logic [3:0][CW-1:0]       bnd_s2, bnd_s3;
	logic signed [XW-1:0]     cu_s3, cv_s3;
	logic signed [XW-1:0]     lo_u_x, hi_u_x, lo_v_x, hi_v_x;
	logic                     in_u, in_v;

	assign org_a = org[AXIS];
	assign dir_a = hdg[AXIS];
	assign org_u = org[U];
	assign org_v = org[V];
	assign hdg_u = hdg[U];
	assign hdg_v = hdg[V];

	// Numerator and divisor magnitudes
	assign diff  = {plane[CW-1], plane} - {org_a[CW-1], org_a};
	assign adiff = diff[CW] ? (~diff + 1'b1) : diff;
	assign dmag  = dir_a[CW-1] ? (~dir_a + 1'b1) : dir_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= div_flag.valid;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Stage 1: take the beat apart into magnitudes and signs
	always_ff @(posedge clk) begin
		nmag_s1 <= NM'(adiff) << FRAC;
		neg_s1  <= diff[CW] ^ dir_a[CW-1];
		zero_s1 <= (dir_a == '0);
		bnd_s1  <= bnd;
	end

	rtbho_div #(
		.CW   (CW),
		.FRAC (FRAC)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s1),
		.nmag     (nmag_s1),
		.dmag     (dmag),
		.neg      (neg_s1),
		.zero     (zero_s1),
		.flag     (div_flag),
		.quot     (div_t)
	);

	// Carry the face bounds alongside the divider
	always_ff @(posedge clk) begin
		bnd_dly_q[0] <= bnd_s1;
		for (int i = 1; i < D; i++) bnd_dly_q[i] <= bnd_dly_q[i-1];
	end

	// Stage 2: distance times cross headings
	assign t_ext = {1'b0, div_t};
	always_ff @(posedge clk) begin
		prod_u_s2 <= t_ext * hdg_u;
		prod_v_s2 <= t_ext * hdg_v;
		t_s2      <= div_t;
		ok_s2     <= div_flag.ok;
		bnd_s2    <= bnd_dly_q[D-1];
	end

	// Stage 3: hit coordinates at full width
	assign sh_u = prod_u_s2 >>> FRAC;
	assign sh_v = prod_v_s2 >>> FRAC;
	always_ff @(posedge clk) begin
		cu_s3  <= {{(CW+1){org_u[CW-1]}}, org_u} + {sh_u[2*CW-1], sh_u};
		cv_s3  <= {{(CW+1){org_v[CW-1]}}, org_v} + {sh_v[2*CW-1], sh_v};
		t_s3   <= t_s2;
		ok_s3  <= ok_s2;
		bnd_s3 <= bnd_s2;
	end

	// Stage 4: inclusive bound checks
	assign lo_u_x = {{(CW+1){bnd_s3[0][CW-1]}}, bnd_s3[0]};
	assign hi_u_x = {{(CW+1){bnd_s3[1][CW-1]}}, bnd_s3[1]};
	assign lo_v_x = {{(CW+1){bnd_s3[2][CW-1]}}, bnd_s3[2]};
	assign hi_v_x = {{(CW+1){bnd_s3[3][CW-1]}}, bnd_s3[3]};
	assign in_u   = (cu_s3 >= lo_u_x) && (cu_s3 <= hi_u_x);
	assign in_v   = (cv_s3 >= lo_v_x) && (cv_s3 <= hi_v_x);

	always_ff @(posedge clk) begin
		hit_s4  <= ok_s3 && in_u && in_v;
		dist_s4 <= t_s3;
	end

	assign flag.valid = vld_s4;
	assign flag.hit   = hit_s4;
	assign face_dist  = dist_s4;

	`RTBHO_ASSERT_IMP(a_face_hit_ok, clk, arst_n, vld_s4 && hit_s4, $past(div_flag.ok, 3), "face hit without usable distance")

endmodule

`default_nettype wire

/* design/ray_two_box_hit_order.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "ray_two_box_hit_order_defines.svh"

// Ray against two boxes. Program the ray origin and heading over the APB
// port while no work is in flight, then pulse start with one box pair per
// cycle: busy is always low and a new pair may enter on every clock. The
// hit_order result appears on done for one cycle; there is no way to hold
// it, so capture it on that cycle. Most of the pipeline lies in the face
// dividers, which resolve one quotient bit per pipeline stage.
module ray_two_box_hit_order #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [((COORD_WIDTH > 32) ? 3 : 2)+2:0] paddr,
	input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
	output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
	output logic                                   pready,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [COORD_WIDTH-1:0]          first_lo_x,
	input  logic signed [COORD_WIDTH-1:0]          first_lo_y,
	input  logic signed [COORD_WIDTH-1:0]          first_lo_z,
	input  logic signed [COORD_WIDTH-1:0]          first_hi_x,
	input  logic signed [COORD_WIDTH-1:0]          first_hi_y,
	input  logic signed [COORD_WIDTH-1:0]          first_hi_z,
	input  logic signed [COORD_WIDTH-1:0]          second_lo_x,
	input  logic signed [COORD_WIDTH-1:0]          second_lo_y,
	input  logic signed [COORD_WIDTH-1:0]          second_lo_z,
	input  logic signed [COORD_WIDTH-1:0]          second_hi_x,
	input  logic signed [COORD_WIDTH-1:0]          second_hi_y,
	input  logic signed [COORD_WIDTH-1:0]          second_hi_z,
	output logic                                   done,
	output logic [2:0]                             hit_order
);
	import rtbho_pkg::*;

	localparam int CW       = COORD_WIDTH;
	localparam int DW       = (CW > 32) ? 64 : 32;
	localparam int ADDR_LSB = (CW > 32) ? 3 : 2;
	localparam int DIST_W   = CW - 1;
	localparam int LAT      = CW + 7;

	logic [AXES-1:0][CW-1:0] org, hdg;
	logic [AXES-1:0][CW-1:0] lo [2];
	logic [AXES-1:0][CW-1:0] hi [2];
	logic                    in_go;

	face_flag_t              fflag [2][6];
	logic [DIST_W-1:0]       fdist [2][6];
	logic                    all_vld;

	logic [DIST_W:0]         near_r1 [2][3];
	logic [DIST_W:0]         near_s1 [2][3];
	logic [DIST_W:0]         near_r2 [2];
	logic [DIST_W:0]         near_s2 [2];
	logic                    vld_s1, vld_s2, vld_s3;
	hit_order_t              code_r3;
	logic [2:0]              hit_order_s3;

	// Keep the nearer of two candidates; a miss never wins
	function automatic logic [DIST_W:0] pick_near(input logic [DIST_W:0] a,
			input logic [DIST_W:0] b);
		return {a[DIST_W] | b[DIST_W],
			(a[DIST_W] && (!b[DIST_W] || (a[DIST_W-1:0] <= b[DIST_W-1:0])))
				? a[DIST_W-1:0] : b[DIST_W-1:0]};
	endfunction

	assign busy  = 1'b0;
	assign in_go = start && !busy;

	rtbho_cfg #(
		.CW       (CW),
		.DW       (DW),
		.ADDR_LSB (ADDR_LSB)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.org     (org),
		.hdg     (hdg)
	);

	assign lo[0] = {first_lo_z, first_lo_y, first_lo_x};
	assign hi[0] = {first_hi_z, first_hi_y, first_hi_x};
	assign lo[1] = {second_lo_z, second_lo_y, second_lo_x};
	assign hi[1] = {second_hi_z, second_hi_y, second_hi_x};

	// Twelve face tests: box, axis, lower or upper plane
	for (genvar b = 0; b < 2; b++) begin : g_box
		for (genvar a = 0; a < AXES; a++) begin : g_axis
			for (genvar s = 0; s < 2; s++) begin : g_side
				localparam int U = (a + 1) % AXES;
				localparam int V = (a + 2) % AXES;
				rtbho_face #(
					.CW   (CW),
					.FRAC (FRAC_BITS),
					.AXIS (a)
				) u_face (
					.clk       (clk),
					.arst_n    (arst_n),
					.in_valid  (in_go),
					.plane     ((s != 0) ? hi[b][a] : lo[b][a]),
					.bnd       ({hi[b][V], lo[b][V], hi[b][U], lo[b][U]}),
					.org       (org),
					.hdg       (hdg),
					.flag      (fflag[b][2*a+s]),
					.face_dist (fdist[b][2*a+s])
				);
			end
		end
	end

	// All faces move in lock step
	always_comb begin
		all_vld = 1'b1;
		for (int b = 0; b < 2; b++)
			for (int f = 0; f < 6; f++) all_vld = all_vld & fflag[b][f].valid;
	end

	// Reduce six faces per box: pairs, then the last three
	always_comb begin
		for (int b = 0; b < 2; b++)
			for (int p = 0; p < 3; p++)
				near_r1[b][p] = pick_near({fflag[b][2*p].hit, fdist[b][2*p]},
					{fflag[b][2*p+1].hit, fdist[b][2*p+1]});
	end

	always_comb begin
		for (int b = 0; b < 2; b++)
			near_r2[b] = pick_near(pick_near(near_s1[b][0], near_s1[b][1]), near_s1[b][2]);
	end

	// Order the two boxes; equal distances favour the first
	always_comb begin
		if (near_s2[0][DIST_W] && near_s2[1][DIST_W])
			code_r3 = (near_s2[1][DIST_W-1:0] < near_s2[0][DIST_W-1:0])
				? HIT_SECOND_NEARER : HIT_FIRST_NEARER;
		else if (near_s2[0][DIST_W])
			code_r3 = HIT_FIRST;
		else if (near_s2[1][DIST_W])
			code_r3 = HIT_SECOND;
		else
			code_r3 = HIT_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= all_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		near_s1      <= near_r1;
		near_s2      <= near_r2;
		hit_order_s3 <= code_r3;
	end

	assign done      = vld_s3;
	assign hit_order = hit_order_s3;

	`RTBHO_ASSERT_IMP(a_top_out_src, clk, arst_n, done, $past(in_go, LAT), "result beat with no entry")
	`RTBHO_ASSERT_IMP(a_top_in_dst, clk, arst_n, $past(in_go, LAT) && $past(arst_n, LAT), done, "entry lost")

endmodule

`default_nettype wire

/* bench/tb_ray_two_box_hit_order.sv */
`timescale 1ns / 1ps

module tb_ray_two_box_hit_order;
	import rtbho_pkg::*;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int LATENCY = CW + 7;

	// Field order: first lo xyz, first hi xyz, second lo xyz, second hi xyz
	typedef logic [11:0][CW-1:0] box_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start;
	logic busy;
	box_pair_t pair_drv;
	logic done;
	logic [2:0] hit_order;

	box_pair_t pending_pairs[$];
	hit_order_t expected_orders[$];
	logic [CW-1:0] ray_regs[6];
	box_pair_t cur_pair;
	int burst_left, gap_left;
	int errors, checked, accepted, settings;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ray_two_box_hit_order i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.first_lo_x(pair_drv[0]), .first_lo_y(pair_drv[1]), .first_lo_z(pair_drv[2]),
		.first_hi_x(pair_drv[3]), .first_hi_y(pair_drv[4]), .first_hi_z(pair_drv[5]),
		.second_lo_x(pair_drv[6]), .second_lo_y(pair_drv[7]), .second_lo_z(pair_drv[8]),
		.second_hi_x(pair_drv[9]), .second_hi_y(pair_drv[10]), .second_hi_z(pair_drv[11]),
		.done(done), .hit_order(hit_order)
	);

	// Nearest hit distance of one box, base 0 for the first box, 6 for the second
	function automatic bit box_nearest(input box_pair_t p, input int base,
			output longint best);
		longint org[3], dir[3], lo[3], hi[3];
		longint plane, num, t, c;
		bit valid, in_face;
		valid = 1'b0;
		best = 0;
		for (int i = 0; i < 3; i++) begin
			org[i] = longint'($signed(ray_regs[i]));
			dir[i] = longint'($signed(ray_regs[3 + i]));
			lo[i] = longint'($signed(p[base + i]));
			hi[i] = longint'($signed(p[base + 3 + i]));
		end
		for (int a = 0; a < 3; a++) begin
			for (int s = 0; s < 2; s++) begin
				if (dir[a] == 0)
					continue;
				plane = s ? hi[a] : lo[a];
				num = (plane - org[a]) * (longint'(1) << FB);
				t = num / dir[a];
				if (t > 64'sh7fff_ffff)
					t = 64'sh7fff_ffff;
				// Behind the origin: miss
				if (t < 0)
					continue;
				in_face = 1'b1;
				for (int k = 0; k < 3; k++) begin
					if (k == a)
						continue;
					c = org[k] + ((t * dir[k]) >>> FB);
					if (c < lo[k] || c > hi[k])
						in_face = 1'b0;
				end
				if (in_face && (!valid || t < best)) begin
					best = t;
					valid = 1'b1;
				end
			end
		end
		return valid;
	endfunction

	function automatic hit_order_t predict_order(input box_pair_t p);
		longint d1, d2;
		bit h1, h2;
		h1 = box_nearest(p, 0, d1);
		h2 = box_nearest(p, 6, d2);
		if (h1 && h2)
			return (d2 < d1) ? HIT_SECOND_NEARER : HIT_FIRST_NEARER;
		if (h1)
			return HIT_FIRST;
		if (h2)
			return HIT_SECOND;
		return HIT_NONE;
	endfunction

	// Driver: issue box pairs in bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			pair_drv <= '0;
			burst_left <= 1;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				expected_orders.push_back(predict_order(cur_pair));
				accepted++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (pending_pairs.size() > 0) begin
					cur_pair = pending_pairs.pop_front();
					pair_drv <= cur_pair;
					start <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_orders.size() == 0) begin
				$error("hit_order beat with no pair outstanding: %0d", hit_order);
				errors++;
			end else begin
				hit_order_t want;
				want = expected_orders.pop_front();
				checked++;
				if (hit_order !== want) begin
					$error("hit_order mismatch: expected %0d, actual %0d", want, hit_order);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		ray_regs[idx] = value;
	endtask

	task automatic set_ray(input logic [31:0] ox, oy, oz, hx, hy, hz);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ORIGIN_Z, oz);
		write_reg(REG_HEADING_X, hx);
		write_reg(REG_HEADING_Y, hy);
		write_reg(REG_HEADING_Z, hz);
		settings++;
	endtask

	// Wait for every pair to drain, then let the pipeline empty
	task automatic drain();
		@(negedge clk);
		while (pending_pairs.size() > 0 || start || expected_orders.size() > 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 400 << FB)) - (200 << FB));
			default: return 32'($signed($urandom_range(0, 40 << FB)) - (20 << FB));
		endcase
	endfunction

	// Box placed around a point on the ray, sometimes broken
	function automatic void rand_box(ref box_pair_t p, input int base);
		longint t, c, h;
		for (int k = 0; k < 3; k++) begin
			t = (k == 0) ? longint'($urandom_range(0, 60 << FB)) : t;
			c = longint'($signed(ray_regs[k])) +
				((t * longint'($signed(ray_regs[3 + k]))) >>> FB);
			h = longint'($urandom_range(0, 8 << FB));
			p[base + k] = 32'(c - h);
			p[base + 3 + k] = 32'(c + h);
		end
		case ($urandom_range(0, 9))
			0: p[base + $urandom_range(0, 5)] = rand_coord();
			1: begin
				int k;
				k = $urandom_range(0, 2);
				{p[base + k], p[base + 3 + k]} = {p[base + 3 + k], p[base + k]};
			end
			2: for (int k = 0; k < 6; k++) p[base + k] = rand_coord();
			default: ;
		endcase
	endfunction

	task automatic queue_random(input int n);
		box_pair_t p;
		repeat (n) begin
			rand_box(p, 0);
			rand_box(p, 6);
			if ($urandom_range(0, 7) == 0)
				p[6 +: 6] = p[0 +: 6];
			if ($urandom_range(0, 19) == 0)
				for (int i = 0; i < 12; i++) p[i] = $urandom;
			pending_pairs.push_back(p);
		end
	endtask

	function automatic box_pair_t make_pair(input logic [31:0] a_lo, a_hi, b_lo, b_hi);
		box_pair_t p;
		for (int i = 0; i < 3; i++) begin
			p[i] = a_lo; p[3 + i] = a_hi; p[6 + i] = b_lo; p[9 + i] = b_hi;
		end
		return p;
	endfunction

	initial begin
		box_pair_t p;
		localparam logic [31:0] ONE = 32'h0001_0000;
		localparam logic [31:0] MAXV = 32'h7fff_ffff;
		localparam logic [31:0] MINV = 32'h8000_0000;
		errors = 0; checked = 0; accepted = 0; settings = 0;
		foreach (ray_regs[i]) ray_regs[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset ray: zero heading, every face misses
		pending_pairs.push_back(make_pair(-ONE, ONE, -ONE, ONE));
		queue_random(40);
		drain();

		// Ray along +x from the origin
		set_ray(0, 0, 0, ONE, 0, 0);
		pending_pairs.push_back(make_pair(-ONE, ONE, 32'(5 * ONE), 32'(6 * ONE)));
		pending_pairs.push_back(make_pair(32'(5 * ONE), 32'(6 * ONE), -ONE, ONE));
		pending_pairs.push_back(make_pair(ONE, 32'(2 * ONE), ONE, 32'(2 * ONE)));
		pending_pairs.push_back(make_pair(ONE, -ONE, -ONE, ONE));
		pending_pairs.push_back(make_pair(-ONE, ONE, ONE, -ONE));
		pending_pairs.push_back(make_pair(ONE, -ONE, ONE, -ONE));
		pending_pairs.push_back(make_pair(MINV, MAXV, MAXV, MAXV));
		pending_pairs.push_back(make_pair(MINV, MINV, 0, 0));
		pending_pairs.push_back(make_pair(MAXV, MINV, MINV, MAXV));
		p = make_pair(-ONE, ONE, -ONE, ONE);
		p[0] = 32'(-3 * ONE); p[3] = 32'(-2 * ONE);
		pending_pairs.push_back(p);
		p[6] = 32'(2 * ONE); p[9] = 32'(3 * ONE);
		pending_pairs.push_back(p);
		p = make_pair(ONE, ONE, 32'(2 * ONE), 32'(2 * ONE));
		p[1] = 0; p[2] = 0; p[4] = 0; p[5] = 0;
		pending_pairs.push_back(p);
		drain();

		// Slanted ray with a small negative distance that truncates to zero
		set_ray(32'h0000_0001, 0, 0, 32'h7fff_ffff, ONE, ONE);
		pending_pairs.push_back(make_pair(0, ONE, -ONE, ONE));
		queue_random(200);
		drain();

		repeat (4) begin
			set_ray(rand_coord(), rand_coord(), rand_coord(),
				32'($signed($urandom_range(0, 8 << FB)) - (4 << FB)),
				($urandom_range(0, 4) == 0) ? 32'h0 : 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB)),
				32'($signed($urandom_range(0, 8 << FB)) - (4 << FB)));
			queue_random(250);
			drain();
		end

		// Extreme rays
		set_ray(MAXV, MINV, MAXV, MINV, MAXV, MINV);
		queue_random(150);
		drain();
		set_ray(MINV, MAXV, 0, MAXV, MINV, 32'h0000_0001);
		queue_random(150);
		drain();
		set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		queue_random(150);
		drain();

		$display("%0d box pairs issued under %0d ray settings, %0d results checked",
			accepted, settings, checked);
		if (errors == 0 && expected_orders.size() == 0)
			$display("ray_two_box_hit_order verification clean");
		else
			$display("ray_two_box_hit_order verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("ray_two_box_hit_order verification failed");
		$finish;
	end

endmodule
